[hw/rtl/dc_motor_ramp_hbridge_driver_unit_assert.svh]
// Assertion macros for the bound assertion checker (dcmr_checker) of the motor driver.
`ifndef DC_MOTOR_RAMP_HBRIDGE_DRIVER_UNIT_ASSERT_SVH
`define DC_MOTOR_RAMP_HBRIDGE_DRIVER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DCMR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DCMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dcmr_pkg.sv]
package dcmr_pkg;

  // Field widths
  localparam int DUTY_W    = 7;
  localparam int RAMP_W    = 16;
  localparam int CMD_W     = 3;
  localparam int MODE_W    = 2;
  localparam int STG_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Defaults for top-level parameters and compare limits
  localparam int DCMR_TIMER_BITS  = 16;
  localparam int DCMR_FULL_ON_DUTY = 100;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START_RAMP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START_DIRECT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DECEL        = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP         = 3'd4;
  localparam logic [CMD_W-1:0] CMD_COAST        = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR        = 3'd6;

  // Leg drive modes
  localparam logic [MODE_W-1:0] MODE_DOWN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_Z    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PWM  = 2'd3;

  // Trajectory stages
  localparam logic [STG_W-1:0] STG_ACCEL = 2'd0;
  localparam logic [STG_W-1:0] STG_CONST = 2'd1;
  localparam logic [STG_W-1:0] STG_DECEL = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_TICKS = 2'd2;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_CALC,
    CTL_PUSH
  } ctl_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_DIV,
    DIV_DONE
  } div_state_t;

  // Request to the serial multiply-divide unit: q = a * m / d
  typedef struct packed {
    logic              start;
    logic [DUTY_W-1:0] a;
    logic [RAMP_W-1:0] m;
    logic [RAMP_W-1:0] d;
  } rdiv_req_t;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] q;
  } rdiv_rsp_t;

  typedef struct packed {
    logic [MODE_W-1:0] u;
    logic [MODE_W-1:0] v;
  } legs_t;

  // Leg modes for a running motor: one leg low, the other PWM or fully up
  function automatic legs_t leg_modes(input logic full_on, input logic dir);
    legs_t       l;
    logic [MODE_W-1:0] other;
    other = full_on ? MODE_UP : MODE_PWM;
    if (!dir) begin
      l.u = MODE_DOWN;
      l.v = other;
    end else begin
      l.u = other;
      l.v = MODE_DOWN;
    end
    return l;
  endfunction

endpackage

[hw/rtl/dcmr_ramp_div.sv]
module dcmr_ramp_div import dcmr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  rdiv_req_t req,
  output rdiv_rsp_t rsp
);

  localparam logic [2:0] LAST_STEP = 3'(DUTY_W - 1);

  div_state_t        st_r, st_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [RAMP_W-1:0] mcand_r, mcand_nxt;
  logic [RAMP_W-1:0] dvsr_r, dvsr_nxt;
  logic [DUTY_W-1:0] mplr_r, mplr_nxt;
  logic [RAMP_W-1:0] acc_r, acc_nxt;
  logic [DUTY_W-1:0] low_r, low_nxt;

  logic [RAMP_W:0]   add_w;
  logic [RAMP_W:0]   trial_w;
  logic [RAMP_W:0]   diff_w;
  logic              ge_w;
  logic              last_w;

  assign last_w  = (cnt_r == LAST_STEP);
  // Multiply digit: add multiplicand when the low multiplier bit is set
  assign add_w   = {1'b0, acc_r} + (mplr_r[0] ? {1'b0, mcand_r} : '0);
  // Divide digit: bring down the next product bit and trial-subtract
  assign trial_w = {acc_r, low_r[DUTY_W-1]};
  assign diff_w  = trial_w - {1'b0, dvsr_r};
  assign ge_w    = (trial_w >= {1'b0, dvsr_r});

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      DIV_IDLE: if (req.start) st_nxt = DIV_MUL;
      DIV_MUL:  if (last_w) st_nxt = DIV_DIV;
      DIV_DIV:  if (last_w) st_nxt = DIV_DONE;
      DIV_DONE: st_nxt = DIV_IDLE;
      default:  st_nxt = DIV_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rsp.done = (st_r == DIV_DONE);
    rsp.q    = low_r;
  end

  // Datapath: product LSB-first into low_r, then quotient MSB-first into low_r
  always_comb begin
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    dvsr_nxt  = dvsr_r;
    mplr_nxt  = mplr_r;
    acc_nxt   = acc_r;
    low_nxt   = low_r;
    case (st_r)
      DIV_IDLE: begin
        if (req.start) begin
          cnt_nxt   = '0;
          mcand_nxt = req.m;
          dvsr_nxt  = req.d;
          mplr_nxt  = req.a;
          acc_nxt   = '0;
          low_nxt   = '0;
        end
      end
      DIV_MUL: begin
        acc_nxt  = add_w[RAMP_W:1];
        low_nxt  = {add_w[0], low_r[DUTY_W-1:1]};
        mplr_nxt = {1'b0, mplr_r[DUTY_W-1:1]};
        cnt_nxt  = last_w ? '0 : cnt_r + 3'd1;
      end
      DIV_DIV: begin
        acc_nxt = ge_w ? diff_w[RAMP_W-1:0] : trial_w[RAMP_W-1:0];
        low_nxt = {low_r[DUTY_W-2:0], ge_w};
        cnt_nxt = last_w ? '0 : cnt_r + 3'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= DIV_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    dvsr_r  <= dvsr_nxt;
    mplr_r  <= mplr_nxt;
    acc_r   <= acc_nxt;
    low_r   <= low_nxt;
  end

endmodule

[hw/rtl/dc_motor_ramp_hbridge_driver_unit.sv]
// DC motor H-bridge driver with linear soft-start / soft-stop duty ramp.
// Input channel (in_valid / in_stall): one command per transaction, with
// rotation_dir used by the start commands. Result channel (out_valid /
// out_stall): exactly one result per command, giving leg modes, duty, run
// flag, stage and status as they stand after the command.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): max_duty,
// accel_ticks, decel_ticks; write only while the block is idle.
// A command runs through the EXEC and PUSH states before its result is
// loaded into the output register and shown on out_valid; a tick on a ramp
// also waits in CALC for the serial multiply-divide unit (7 multiply digits
// and 7 quotient digits, one per cycle, plus hand-off). One command is in
// flight at a time; a new one is taken the cycle after the previous result
// enters the output register. A stalled result holds in the output register
// and keeps the next command's result waiting in PUSH.
// Reset (rst_n low, synchronous) stops the motor, pulls both legs down,
// clears duty, timer and stage, and loads the register defaults.
module dc_motor_ramp_hbridge_driver_unit import dcmr_pkg::*; #(
  parameter int TIMER_BITS = DCMR_TIMER_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_command,
  input  logic                 in_rotation_dir,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [MODE_W-1:0]    out_leg_u_mode,
  output logic [MODE_W-1:0]    out_leg_v_mode,
  output logic [DUTY_W-1:0]    out_duty_out,
  output logic                 out_running_out,
  output logic [STG_W-1:0]     out_stage_out,
  output logic                 out_status_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RAMP_W-1:0]    cfg_data
);

  localparam int CW = (TIMER_BITS > RAMP_W) ? TIMER_BITS : RAMP_W;

  ctl_state_t            st_r, st_nxt;
  logic [CMD_W-1:0]      cmd_r;
  logic                  dir_r;

  logic [DUTY_W-1:0]     max_duty_r;
  logic [RAMP_W-1:0]     accel_r;
  logic [RAMP_W-1:0]     decel_r;

  logic                  running_r, running_nxt;
  logic [STG_W-1:0]      stage_r, stage_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [DUTY_W-1:0]     duty_r, duty_nxt;
  logic [DUTY_W-1:0]     peak_r, peak_nxt;
  logic                  spin_r, spin_nxt;
  logic [MODE_W-1:0]     u_r, u_nxt;
  logic [MODE_W-1:0]     v_r, v_nxt;
  logic                  status_r, status_nxt;

  logic                  out_valid_r;
  logic                  out_load;
  logic                  in_take;

  logic [TIMER_BITS-1:0] t_new;
  logic [CW-1:0]         t_ext;
  logic [RAMP_W-1:0]     t16;
  logic                  accel_on, decel_on;
  logic                  need_div;
  legs_t                 legs_now;
  legs_t                 legs_max;
  legs_t                 legs_q;
  rdiv_req_t             dreq;
  rdiv_rsp_t             drsp;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (st_r == CTL_PUSH) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  // Tick arithmetic: saturating timer and ramp-end compares
  assign t_new    = (&timer_r) ? timer_r : timer_r + 1'b1;
  assign t_ext    = CW'(t_new);
  assign t16      = t_ext[RAMP_W-1:0];
  assign accel_on = (t_ext < CW'(accel_r));
  assign decel_on = (t_ext < CW'(decel_r));
  assign need_div = (st_r == CTL_EXEC) && (cmd_r == CMD_TICK) && running_r &&
                    (((stage_r == STG_ACCEL) && accel_on) ||
                     ((stage_r == STG_DECEL) && decel_on));

  assign legs_now = leg_modes(32'(duty_r) >= 32'(DCMR_FULL_ON_DUTY), spin_r);
  assign legs_max = leg_modes(32'(max_duty_r) >= 32'(DCMR_FULL_ON_DUTY), spin_r);
  assign legs_q   = leg_modes(32'(drsp.q) >= 32'(DCMR_FULL_ON_DUTY), spin_r);

  // Ramp operands: accel max*t/A, decel peak*(D-t)/D
  always_comb begin
    dreq.start = need_div;
    if (stage_r == STG_ACCEL) begin
      dreq.a = max_duty_r;
      dreq.m = t16;
      dreq.d = accel_r;
    end else begin
      dreq.a = peak_r;
      dreq.m = decel_r - t16;
      dreq.d = decel_r;
    end
  end

  dcmr_ramp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      CTL_IDLE: if (in_take) st_nxt = CTL_EXEC;
      CTL_EXEC: st_nxt = need_div ? CTL_CALC : CTL_PUSH;
      CTL_CALC: if (drsp.done) st_nxt = CTL_PUSH;
      CTL_PUSH: if (out_load) st_nxt = CTL_IDLE;
      default:  st_nxt = CTL_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_stall = (st_r != CTL_IDLE);
  end

  // Motor state update
  always_comb begin
    running_nxt = running_r;
    stage_nxt   = stage_r;
    timer_nxt   = timer_r;
    duty_nxt    = duty_r;
    peak_nxt    = peak_r;
    spin_nxt    = spin_r;
    u_nxt       = u_r;
    v_nxt       = v_r;
    status_nxt  = status_r;
    if (st_r == CTL_EXEC) begin
      status_nxt = 1'b0;
      case (cmd_r)
        CMD_TICK: begin
          if (running_r) begin
            timer_nxt = t_new;
            case (stage_r)
              STG_ACCEL: begin
                if (!accel_on) begin
                  duty_nxt  = max_duty_r;
                  peak_nxt  = max_duty_r;
                  stage_nxt = STG_CONST;
                  u_nxt     = legs_max.u;
                  v_nxt     = legs_max.v;
                end
              end
              STG_DECEL: begin
                if (!decel_on) begin
                  duty_nxt    = max_duty_r;
                  stage_nxt   = STG_CONST;
                  running_nxt = 1'b0;
                  u_nxt       = MODE_DOWN;
                  v_nxt       = MODE_DOWN;
                end
              end
              default: begin
                u_nxt = legs_now.u;
                v_nxt = legs_now.v;
              end
            endcase
          end
        end
        CMD_START_RAMP: begin
          if (running_r) begin
            status_nxt = 1'b1;
            if (stage_r != STG_DECEL) begin
              stage_nxt = STG_DECEL;
              timer_nxt = '0;
            end
          end else begin
            spin_nxt    = dir_r;
            duty_nxt    = '0;
            stage_nxt   = STG_ACCEL;
            timer_nxt   = '0;
            running_nxt = 1'b1;
          end
        end
        CMD_START_DIRECT: begin
          if (running_r) begin
            status_nxt = 1'b1;
          end else begin
            spin_nxt    = dir_r;
            stage_nxt   = STG_CONST;
            timer_nxt   = '0;
            running_nxt = 1'b1;
          end
        end
        CMD_DECEL: begin
          if (stage_r != STG_DECEL) begin
            stage_nxt = STG_DECEL;
            timer_nxt = '0;
          end
        end
        CMD_STOP: begin
          running_nxt = 1'b0;
          u_nxt       = MODE_DOWN;
          v_nxt       = MODE_DOWN;
        end
        CMD_COAST: begin
          running_nxt = 1'b0;
          u_nxt       = MODE_Z;
          v_nxt       = MODE_Z;
        end
        CMD_CLEAR: begin
          running_nxt = 1'b0;
          duty_nxt    = '0;
          peak_nxt    = '0;
        end
        default: begin
        end
      endcase
    end else if ((st_r == CTL_CALC) && drsp.done) begin
      // Apply the ramp quotient
      duty_nxt = drsp.q;
      if (stage_r == STG_ACCEL) peak_nxt = drsp.q;
      u_nxt = legs_q.u;
      v_nxt = legs_q.v;
    end
  end

  // Control and motor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= CTL_IDLE;
      out_valid_r <= 1'b0;
      running_r   <= 1'b0;
      stage_r     <= STG_ACCEL;
      timer_r     <= '0;
      duty_r      <= '0;
      peak_r      <= '0;
      spin_r      <= 1'b0;
      u_r         <= MODE_DOWN;
      v_r         <= MODE_DOWN;
      status_r    <= 1'b0;
      max_duty_r  <= 7'd100;
      accel_r     <= 16'd1000;
      decel_r     <= 16'd1000;
    end else begin
      st_r      <= st_nxt;
      running_r <= running_nxt;
      stage_r   <= stage_nxt;
      timer_r   <= timer_nxt;
      duty_r    <= duty_nxt;
      peak_r    <= peak_nxt;
      spin_r    <= spin_nxt;
      u_r       <= u_nxt;
      v_r       <= v_nxt;
      status_r  <= status_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_DUTY:    max_duty_r <= cfg_data[DUTY_W-1:0];
          REG_ACCEL_TICKS: accel_r    <= cfg_data;
          REG_DECEL_TICKS: decel_r    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Hold the command; load the result register
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r <= in_command;
      dir_r <= in_rotation_dir;
    end
    if (out_load) begin
      out_leg_u_mode  <= u_r;
      out_leg_v_mode  <= v_r;
      out_duty_out    <= duty_r;
      out_running_out <= running_r;
      out_stage_out   <= stage_r;
      out_status_out  <= status_r;
    end
  end

endmodule

[hw/rtl/dcmr_checker.sv]
`include "dc_motor_ramp_hbridge_driver_unit_assert.svh"

module dcmr_checker import dcmr_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [CMD_W-1:0]     in_command,
  input logic                 in_rotation_dir,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [MODE_W-1:0]    out_leg_u_mode,
  input logic [MODE_W-1:0]    out_leg_v_mode,
  input logic [DUTY_W-1:0]    out_duty_out,
  input logic                 out_running_out,
  input logic [STG_W-1:0]     out_stage_out,
  input logic                 out_status_out,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [RAMP_W-1:0]    cfg_data
);

  // Hold a stalled result
  `DCMR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_leg_u_mode) && $stable(out_leg_v_mode) && $stable(out_duty_out) && $stable(out_stage_out), "stalled result changed")

  // Keep one command in flight: block input right after a transaction
  `DCMR_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second command taken while busy")

  // Never drive both legs away from ground unless both float
  `DCMR_ASSERT_NOW(a_no_shoot, out_valid, (out_leg_u_mode == MODE_DOWN) || (out_leg_v_mode == MODE_DOWN) || ((out_leg_u_mode == MODE_Z) && (out_leg_v_mode == MODE_Z)), "unsafe leg pair")

  // Reject a start only while running
  `DCMR_ASSERT_NOW(a_status_run, out_valid && out_status_out, out_running_out, "rejected start without run flag")

endmodule

bind dc_motor_ramp_hbridge_driver_unit dcmr_checker u_dcmr_checker (.*);

[tb/hbridge_drive_checker.sv]
`timescale 1ns / 100ps

module hbridge_drive_checker import dcmr_pkg::*; #(
  parameter int TIMER_BITS = DCMR_TIMER_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [CMD_W-1:0]     in_command,
  input  logic                 in_rotation_dir,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [MODE_W-1:0]    out_leg_u_mode,
  input  logic [MODE_W-1:0]    out_leg_v_mode,
  input  logic [DUTY_W-1:0]    out_duty_out,
  input  logic                 out_running_out,
  input  logic [STG_W-1:0]     out_stage_out,
  input  logic                 out_status_out,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RAMP_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   pending
);

  typedef struct packed {
    logic [MODE_W-1:0] leg_u;
    logic [MODE_W-1:0] leg_v;
    logic [DUTY_W-1:0] duty;
    logic              running;
    logic [STG_W-1:0]  stage;
    logic              status;
  } drive_result_t;

  // Register copy
  logic [DUTY_W-1:0]     max_duty;
  logic [RAMP_W-1:0]     accel_ticks;
  logic [RAMP_W-1:0]     decel_ticks;

  // Motor state copy
  logic                  motor_on;
  logic [STG_W-1:0]      ramp_stage;
  logic [TIMER_BITS-1:0] tick_count;
  logic [DUTY_W-1:0]     duty_now;
  logic [DUTY_W-1:0]     duty_peak;
  logic                  spin_ccw;
  logic [MODE_W-1:0]     leg_u_now;
  logic [MODE_W-1:0]     leg_v_now;

  drive_result_t         drive_q[$];

  function automatic void load_defaults();
    max_duty    = 7'd100;
    accel_ticks = 16'd1000;
    decel_ticks = 16'd1000;
    motor_on    = 1'b0;
    ramp_stage  = STG_ACCEL;
    tick_count  = '0;
    duty_now    = '0;
    duty_peak   = '0;
    spin_ccw    = 1'b0;
    leg_u_now   = MODE_DOWN;
    leg_v_now   = MODE_DOWN;
  endfunction

  function automatic void enter_decel();
    if (ramp_stage != STG_DECEL) begin
      ramp_stage = STG_DECEL;
      tick_count = '0;
    end
  endfunction

  function automatic void halt_legs(input logic [MODE_W-1:0] mode);
    motor_on  = 1'b0;
    leg_u_now = mode;
    leg_v_now = mode;
  endfunction

  // Advance the ramp by one PWM tick and derive the leg drive
  function automatic void pwm_tick();
    logic [31:0]       t;
    logic [31:0]       num;
    logic [MODE_W-1:0] drive_leg;
    if (!motor_on) return;
    if (tick_count != {TIMER_BITS{1'b1}}) tick_count = tick_count + 1'b1;
    t = 32'(tick_count);
    if (ramp_stage == STG_ACCEL) begin
      if (t < accel_ticks) begin
        num      = max_duty * t;
        duty_now = DUTY_W'(num / accel_ticks);
      end else begin
        duty_now   = max_duty;
        ramp_stage = STG_CONST;
      end
      duty_peak = duty_now;
    end else if (ramp_stage == STG_DECEL) begin
      if (t < decel_ticks) begin
        num      = duty_peak * (decel_ticks - t);
        duty_now = DUTY_W'(num / decel_ticks);
      end else begin
        // end of the soft stop: stop right away
        duty_now   = max_duty;
        ramp_stage = STG_CONST;
        halt_legs(MODE_DOWN);
        return;
      end
    end
    drive_leg = (duty_now >= DCMR_FULL_ON_DUTY) ? MODE_UP : MODE_PWM;
    if (!spin_ccw) begin
      leg_u_now = MODE_DOWN;
      leg_v_now = drive_leg;
    end else begin
      leg_u_now = drive_leg;
      leg_v_now = MODE_DOWN;
    end
  endfunction

  // Apply one command and return the drive state it leaves
  function automatic drive_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic dir);
    drive_result_t r;
    logic          rejected;
    rejected = 1'b0;
    case (cmd)
      CMD_TICK: begin
        pwm_tick();
      end
      CMD_START_RAMP: begin
        if (motor_on) begin
          rejected = 1'b1;
          enter_decel();
        end else begin
          spin_ccw   = dir;
          duty_now   = '0;
          ramp_stage = STG_ACCEL;
          tick_count = '0;
          motor_on   = 1'b1;
        end
      end
      CMD_START_DIRECT: begin
        if (motor_on) begin
          rejected = 1'b1;
        end else begin
          spin_ccw   = dir;
          ramp_stage = STG_CONST;
          tick_count = '0;
          motor_on   = 1'b1;
        end
      end
      CMD_DECEL: begin
        enter_decel();
      end
      CMD_STOP: begin
        halt_legs(MODE_DOWN);
      end
      CMD_COAST: begin
        halt_legs(MODE_Z);
      end
      CMD_CLEAR: begin
        motor_on  = 1'b0;
        duty_now  = '0;
        duty_peak = '0;
      end
      default: begin
      end
    endcase
    r.leg_u   = leg_u_now;
    r.leg_v   = leg_v_now;
    r.duty    = duty_now;
    r.running = motor_on;
    r.stage   = ramp_stage;
    r.status  = rejected;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    drive_result_t got;
    drive_result_t want;
    if (!rst_n) begin
      load_defaults();
      drive_q.delete();
    end else begin
      // Compare each result transaction with the oldest prediction
      if (out_valid && !out_stall) begin
        got.leg_u   = out_leg_u_mode;
        got.leg_v   = out_leg_v_mode;
        got.duty    = out_duty_out;
        got.running = out_running_out;
        got.stage   = out_stage_out;
        got.status  = out_status_out;
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no command pending: u=%0d v=%0d duty=%0d",
                     $realtime, got.leg_u, got.leg_v, got.duty);
        end else begin
          want = drive_q.pop_front();
          if (got.leg_u !== want.leg_u || got.leg_v !== want.leg_v ||
              got.duty !== want.duty || got.running !== want.running ||
              got.stage !== want.stage || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: drive mismatch exp u=%0d v=%0d duty=%0d run=%0d stage=%0d",
                       $realtime, want.leg_u, want.leg_v, want.duty, want.running,
                       want.stage,
                       " status=%0d got u=%0d v=%0d duty=%0d run=%0d stage=%0d status=%0d",
                       want.status, got.leg_u, got.leg_v, got.duty,
                       got.running, got.stage, got.status);
          end
        end
      end
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_DUTY:    max_duty    = cfg_data[DUTY_W-1:0];
          REG_ACCEL_TICKS: accel_ticks = cfg_data;
          REG_DECEL_TICKS: decel_ticks = cfg_data;
          default: begin
          end
        endcase
      end
      // Predict each accepted command transaction
      if (in_valid && !in_stall)
        drive_q.push_back(apply_command(in_command, in_rotation_dir));
    end
    pending = drive_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import dcmr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int RX_HOLD_CYCLES = 250;
  localparam int RAND_PHASES    = 10;
  localparam int RAND_CMDS      = 1100;
  localparam int SETTLE_CYCLES  = 24;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_command = CMD_TICK;
  logic                 in_rotation_dir = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [MODE_W-1:0]    out_leg_u_mode;
  logic [MODE_W-1:0]    out_leg_v_mode;
  logic [DUTY_W-1:0]    out_duty_out;
  logic                 out_running_out;
  logic [STG_W-1:0]     out_stage_out;
  logic                 out_status_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_DUTY;
  logic [RAMP_W-1:0]    cfg_data = '0;
  int                   mismatches;
  int                   pending;

  bit                   rx_hold_req = 1'b0;
  int                   cmds_sent = 0;
  logic [RAMP_W-1:0]    cur_accel = 16'd1000;
  logic [RAMP_W-1:0]    cur_decel = 16'd1000;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dc_motor_ramp_hbridge_driver_unit uut (.*);

  hbridge_drive_checker chk (.*);

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [CMD_W-1:0] random_cmd();
    if ($urandom_range(0, 15) == 0) return CMD_UNUSED;
    return CMD_W'($urandom_range(0, 6));
  endfunction

  function automatic logic random_dir();
    return 1'($urandom_range(0, 1));
  endfunction

  // Offer one command transaction and hold it until taken
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic dir, input bit quiet);
    int gap;
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_rotation_dir <= dir;
    do @(posedge clk); while (in_stall);
    cmds_sent++;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every result to come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAMP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ACCEL_TICKS) cur_accel = data;
    if (idx == REG_DECEL_TICKS) cur_decel = data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [DUTY_W-1:0] peak, input logic [RAMP_W-1:0] acc,
                           input logic [RAMP_W-1:0] dec);
    drain();
    write_reg(REG_MAX_DUTY, RAMP_W'(peak));
    write_reg(REG_ACCEL_TICKS, acc);
    write_reg(REG_DECEL_TICKS, dec);
  endtask

  task automatic tick_or_noise(input bit quiet);
    if ($urandom_range(0, 19) == 0) send_cmd(random_cmd(), random_dir(), quiet);
    else send_cmd(CMD_TICK, random_dir(), quiet);
  endtask

  // One start / ramp up / slow down / stop sequence with random content
  task automatic ramp_run();
    bit quiet;
    int n;
    quiet = ($urandom_range(0, 3) == 0);
    send_cmd(($urandom_range(0, 3) != 0) ? CMD_START_RAMP : CMD_START_DIRECT,
             random_dir(), quiet);
    n = ((cur_accel > 30) ? 30 : int'(cur_accel)) + $urandom_range(0, 3);
    repeat (n) tick_or_noise(quiet);
    case ($urandom_range(0, 5))
      0, 1, 2: send_cmd(CMD_DECEL, random_dir(), quiet);
      3:       send_cmd(CMD_START_RAMP, random_dir(), quiet);
      4:       send_cmd(CMD_STOP, random_dir(), quiet);
      default: send_cmd(CMD_COAST, random_dir(), quiet);
    endcase
    n = ((cur_decel > 30) ? 30 : int'(cur_decel)) + $urandom_range(0, 3);
    repeat (n) tick_or_noise(quiet);
    if ($urandom_range(0, 3) == 0)
      send_cmd(CMD_W'($urandom_range(CMD_STOP, CMD_CLEAR)), random_dir(), quiet);
  endtask

  // Result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int n;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        n = RX_HOLD_CYCLES;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = 1 + idle_len();
      end else begin
        out_stall <= 1'b0;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin : stimulus
    int p;
    int phase_goal;
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: register defaults first
    send_cmd(CMD_TICK, 1'b0, 1'b0);
    send_cmd(CMD_UNUSED, 1'b1, 1'b0);
    send_cmd(CMD_START_RAMP, 1'b0, 1'b0);
    send_cmd(CMD_TICK, 1'b0, 1'b0);
    send_cmd(CMD_START_DIRECT, 1'b1, 1'b0);
    send_cmd(CMD_CLEAR, 1'b0, 1'b0);

    // Directed: short ramps, rejected starts, stops and freewheel
    configure(7'd100, 16'd4, 16'd3);
    send_cmd(CMD_START_RAMP, 1'b1, 1'b0);
    repeat (5) send_cmd(CMD_TICK, 1'b0, 1'b0);
    send_cmd(CMD_START_RAMP, 1'b0, 1'b0);
    send_cmd(CMD_DECEL, 1'b0, 1'b0);
    repeat (3) send_cmd(CMD_TICK, 1'b1, 1'b0);
    send_cmd(CMD_START_DIRECT, 1'b0, 1'b0);
    send_cmd(CMD_TICK, 1'b0, 1'b0);
    send_cmd(CMD_COAST, 1'b0, 1'b0);
    send_cmd(CMD_DECEL, 1'b1, 1'b0);
    send_cmd(CMD_START_DIRECT, 1'b1, 1'b0);
    send_cmd(CMD_STOP, 1'b0, 1'b0);
    send_cmd(CMD_TICK, 1'b1, 1'b0);

    // Random phases over a spread of register settings
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       configure(7'd0, 16'd1, 16'd1);
        1:       configure(7'd100, 16'hFFFF, 16'hFFFF);
        2:       configure(7'd127, 16'd7, 16'd9);
        3:       configure(7'd1, 16'hFFFF, 16'd1);
        4:       configure(7'd100, 16'd1, 16'hFFFF);
        default: configure(DUTY_W'($urandom_range(0, 100)), RAMP_W'($urandom_range(1, 24)),
                           RAMP_W'($urandom_range(1, 24)));
      endcase
      if (p == 2 || p == 6) rx_hold_req = 1'b1;
      phase_goal = cmds_sent + RAND_CMDS / RAND_PHASES;
      while (cmds_sent < phase_goal) begin
        if ($urandom_range(0, 4) != 0) ramp_run();
        else send_cmd(random_cmd(), random_dir(), 1'b0);
      end
    end

    // Drain, with a bound
    in_valid <= 1'b0;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (pending != 0 && n < 20000);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
